// ----- hw/rtl/first_match_route_table_assert.svh -----
//==============================================================================
// first_match_route_table_assert.svh
// Assertion macros used by the route table RTL.
//==============================================================================
`ifndef FIRST_MATCH_ROUTE_TABLE_ASSERT_SVH
`define FIRST_MATCH_ROUTE_TABLE_ASSERT_SVH

// same-cycle implication
`define FRT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route table assertion failed");

// next-cycle implication
`define FRT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route table assertion failed");

`endif

// ----- hw/rtl/frt_pkg.sv -----
//==============================================================================
// frt_pkg
// Types and codes of the first-match route table.
//==============================================================================
package frt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] gateway;
    logic [31:0] mask;
    logic [7:0]  flags;
    logic [31:0] metric;
    logic [1:0]  port;
  } entry_t;

  typedef struct packed {
    status_t status;
    logic    matched;
    entry_t  entry;
  } result_t;

endpackage

// ----- hw/rtl/first_match_route_table.sv -----
//==============================================================================
// first_match_route_table
// Ordered route table with append, first-match lookup and clear.
//==============================================================================
// One command word is taken at a time. Add, clear, an unused opcode and a
// lookup on an empty table go from acceptance straight to the result state.
// A lookup scans from entry 0 and stops at the first matching entry (the last
// held entry if none matches): the entry store has a single read port and the
// scan compares one entry per cycle. Results sit in an output register, so a
// new command is taken while a result waits.
`include "first_match_route_table_assert.svh"

module first_match_route_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] route_dest,
  input  logic [31:0] route_gateway,
  input  logic [31:0] route_mask,
  input  logic [7:0]  route_flags,
  input  logic [31:0] route_metric,
  input  logic [1:0]  route_port,
  input  logic [31:0] query_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        matched,
  output logic [31:0] hit_dest,
  output logic [31:0] hit_gateway,
  output logic [31:0] hit_mask,
  output logic [7:0]  hit_flags,
  output logic [31:0] hit_metric,
  output logic [1:0]  hit_port
);
  import frt_pkg::*;

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_res;

  frt_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  frt_ctrl #(
    .DEPTH   (TABLE_DEPTH),
    .ADDR_W  (ADDR_W),
    .COUNT_W (COUNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .route_dest    (route_dest),
    .route_gateway (route_gateway),
    .route_mask    (route_mask),
    .route_flags   (route_flags),
    .route_metric  (route_metric),
    .route_port    (route_port),
    .query_addr    (query_addr),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  // output word register
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign status      = out_res.status;
  assign matched     = out_res.matched;
  assign hit_dest    = out_res.entry.dest;
  assign hit_gateway = out_res.entry.gateway;
  assign hit_mask    = out_res.entry.mask;
  assign hit_flags   = out_res.entry.flags;
  assign hit_metric  = out_res.entry.metric;
  assign hit_port    = out_res.entry.port;

  `FRT_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `FRT_ASSERT_IMP(a_no_accept_with_result, clk, rst, res_valid, in_stall)
  `FRT_ASSERT_IMP(a_out_from_result, clk, rst, $rose(out_valid), $past(res_valid))
  `FRT_ASSERT_IMP(a_full_no_hit, clk, rst, out_valid && status != ST_OK, !matched)

endmodule

// ----- hw/rtl/frt_mem.sv -----
//==============================================================================
// frt_mem
// Route entry store: one write port, one read port, registered read data.
//==============================================================================
module frt_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  frt_pkg::entry_t     wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output frt_pkg::entry_t     rd_data
);
  import frt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/frt_ctrl.sv -----
//==============================================================================
// frt_ctrl
// Command sequencer: appends, clears and scans the entry store in order.
//==============================================================================
module frt_ctrl #(
  parameter int DEPTH   = 16,
  parameter int ADDR_W  = 4,
  parameter int COUNT_W = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [31:0]         route_dest,
  input  logic [31:0]         route_gateway,
  input  logic [31:0]         route_mask,
  input  logic [7:0]          route_flags,
  input  logic [31:0]         route_metric,
  input  logic [1:0]          route_port,
  input  logic [31:0]         query_addr,
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output frt_pkg::entry_t     wr_data,
  output logic                rd_en,
  output logic [ADDR_W-1:0]   rd_addr,
  input  frt_pkg::entry_t     rd_data,
  output logic                res_valid,
  input  logic                res_ready,
  output frt_pkg::result_t    res
);
  import frt_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

  state_t             state, state_next;
  logic [1:0]         op;
  logic [31:0]        query;
  entry_t             new_entry;
  entry_t             pick;
  logic               pick_hit;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] chk_idx;
  logic [COUNT_W-1:0] nxt;
  logic               more;
  logic               hit;
  logic               scan_done;
  logic               full;

  assign nxt       = chk_idx + COUNT_W'(1);
  assign more      = nxt < count;
  assign hit       = ((query ^ rd_data.dest) & rd_data.mask) == 32'd0;
  assign full      = count == FULL_COUNT;
  assign scan_done = hit || !more;
  assign in_stall  = state != S_IDLE;
  assign wr_addr   = count[ADDR_W-1:0];
  assign wr_data   = new_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = chk_idx[ADDR_W-1:0];
    wr_en      = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_LOOKUP && count != '0) begin
            state_next = S_LOAD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_LOAD: begin
        rd_en      = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (more) begin
          rd_addr = nxt[ADDR_W-1:0];
        end
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        res_valid = 1'b1;
        unique case (op)
          OP_ADD: begin
            res.status = full ? ST_FULL : ST_OK;
            wr_en      = res_ready && !full;
          end
          OP_LOOKUP: begin
            if (count == '0) begin
              res.status = ST_EMPTY;
            end else begin
              res.status  = ST_OK;
              res.matched = pick_hit;
              res.entry   = pick;
            end
          end
          default: res.status = ST_OK;
        endcase
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op                <= opcode;
      query             <= query_addr;
      new_entry.dest    <= route_dest;
      new_entry.gateway <= route_gateway;
      new_entry.mask    <= route_mask;
      new_entry.flags   <= route_flags;
      new_entry.metric  <= route_metric;
      new_entry.port    <= route_port;
      chk_idx           <= '0;
    end
    if (state == S_SCAN) begin
      if (scan_done) begin
        pick     <= rd_data;
        pick_hit <= hit;
      end else begin
        chk_idx <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_FINISH && res_ready) begin
      if (op == OP_ADD && !full) begin
        count <= count + COUNT_W'(1);
      end else if (op == OP_CLEAR) begin
        count <= '0;
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
//==============================================================================
// testbench
// Regression for the first-match route table: directed cases on the empty,
// single-entry and full table, a long output hold-off, then random add,
// lookup, clear and unused-opcode runs checked against a bench table model.
//==============================================================================
module testbench;
  import frt_pkg::*;

  localparam int          ROUTE_DEPTH = 16;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          WORD_TARGET = 2000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [31:0] route_dest;
  logic [31:0] route_gateway;
  logic [31:0] route_mask;
  logic [7:0]  route_flags;
  logic [31:0] route_metric;
  logic [1:0]  route_port;
  logic [31:0] query_addr;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic        matched;
  logic [31:0] hit_dest;
  logic [31:0] hit_gateway;
  logic [31:0] hit_mask;
  logic [7:0]  hit_flags;
  logic [31:0] hit_metric;
  logic [1:0]  hit_port;

  // bench copy of the route table
  entry_t  route_tbl [ROUTE_DEPTH];
  int      route_cnt;
  result_t due_answers [$];

  int words_sent;
  int err_count;
  int cycle_count;
  int burst_left;
  bit pace_gaps;
  bit hold_req;

  first_match_route_table #(
    .TABLE_DEPTH(ROUTE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .route_dest(route_dest),
    .route_gateway(route_gateway),
    .route_mask(route_mask),
    .route_flags(route_flags),
    .route_metric(route_metric),
    .route_port(route_port),
    .query_addr(query_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .matched(matched),
    .hit_dest(hit_dest),
    .hit_gateway(hit_gateway),
    .hit_mask(hit_mask),
    .hit_flags(hit_flags),
    .hit_metric(hit_metric),
    .hit_port(hit_port)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count,
               due_answers.size());
      $display("first_match_route_table regression: fail");
      $finish;
    end
  end

  function automatic result_t resolve_route(input logic [1:0] op, input entry_t e,
                                            input logic [31:0] q);
    result_t r;
    int      k;
    int      pick;
    bit      found;
    r = '0;
    case (op)
      OP_ADD: begin
        if (route_cnt >= ROUTE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          route_tbl[route_cnt] = e;
          route_cnt++;
          r.status = ST_OK;
        end
      end
      OP_CLEAR: begin
        route_cnt = 0;
        r.status = ST_OK;
      end
      OP_LOOKUP: begin
        if (route_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          found = 1'b0;
          pick = route_cnt - 1;
          for (k = 0; k < route_cnt; k++) begin
            if (!found && ((q & route_tbl[k].mask) ==
                           (route_tbl[k].dest & route_tbl[k].mask))) begin
              found = 1'b1;
              pick = k;
            end
          end
          r.status = ST_OK;
          r.matched = found;
          r.entry = route_tbl[pick];
        end
      end
      default: r.status = ST_OK;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_answers.size() == 0) begin
        report_mismatch("unexpected word", {30'd0, status}, 32'd0);
      end else begin
        want = due_answers.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (matched !== want.matched)
          report_mismatch("matched", 32'(matched), 32'(want.matched));
        if (hit_dest !== want.entry.dest) report_mismatch("hit_dest", hit_dest, want.entry.dest);
        if (hit_gateway !== want.entry.gateway)
          report_mismatch("hit_gateway", hit_gateway, want.entry.gateway);
        if (hit_mask !== want.entry.mask) report_mismatch("hit_mask", hit_mask, want.entry.mask);
        if (hit_flags !== want.entry.flags)
          report_mismatch("hit_flags", 32'(hit_flags), 32'(want.entry.flags));
        if (hit_metric !== want.entry.metric)
          report_mismatch("hit_metric", hit_metric, want.entry.metric);
        if (hit_port !== want.entry.port)
          report_mismatch("hit_port", 32'(hit_port), 32'(want.entry.port));
      end
    end
  end

  // receiver: own stall pattern, plus a long counted hold-off on request
  initial begin
    int stall_mode;
    int mode_left;
    stall_mode = 0;
    mode_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          default: out_stall = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input entry_t e, input logic [31:0] q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = pace_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    opcode = op;
    route_dest = e.dest;
    route_gateway = e.gateway;
    route_mask = e.mask;
    route_flags = e.flags;
    route_metric = e.metric;
    route_port = e.port;
    query_addr = q;
    do @(posedge clk); while (in_stall);
    due_answers.push_back(resolve_route(op, e, q));
    words_sent++;
  endtask

  function automatic entry_t make_entry(input logic [31:0] dest, input logic [31:0] gw,
                                        input logic [31:0] mask, input logic [7:0] flags,
                                        input logic [31:0] metric, input logic [1:0] port);
    entry_t e;
    e.dest = dest;
    e.gateway = gw;
    e.mask = mask;
    e.flags = flags;
    e.metric = metric;
    e.port = port;
    return e;
  endfunction

  function automatic entry_t rand_entry();
    entry_t e;
    int     plen;
    e.dest = $urandom;
    e.gateway = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    plen = $urandom_range(0, 32);
    if ($urandom_range(0, 7) == 0) e.mask = $urandom;
    else e.mask = (plen == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - plen));
    e.flags = 8'($urandom);
    e.metric = $urandom;
    e.port = 2'($urandom);
    return e;
  endfunction

  // mostly addresses that fall inside a held prefix
  function automatic logic [31:0] pick_query();
    int k;
    if (route_cnt > 0 && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, route_cnt - 1);
      return (route_tbl[k].dest & route_tbl[k].mask) | ($urandom & ~route_tbl[k].mask);
    end
    return $urandom;
  endfunction

  task automatic test_empty_table();
    send_word(OP_LOOKUP, rand_entry(), $urandom);
    send_word(OP_UNUSED, make_entry('1, '1, '1, '1, '1, '1), '1);
    send_word(OP_CLEAR, rand_entry(), $urandom);
  endtask

  task automatic test_first_match();
    send_word(OP_ADD, make_entry('1, '0, '1, '1, '1, 2'd3), $urandom);
    send_word(OP_ADD, make_entry('0, '1, '0, '0, '0, 2'd0), $urandom);
    send_word(OP_LOOKUP, rand_entry(), 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, rand_entry(), 32'h0000_0000);
  endtask

  task automatic test_default_route();
    send_word(OP_CLEAR, rand_entry(), $urandom);
    send_word(OP_ADD, make_entry(32'h0, 32'hC0A8_0001, '1, 8'h5A, 32'd7, 2'd1), $urandom);
    send_word(OP_LOOKUP, rand_entry(), 32'h0000_0001);
  endtask

  task automatic test_table_full();
    int k;
    for (k = 1; k < ROUTE_DEPTH; k++)
      send_word(OP_ADD, make_entry(32'(32'h0A00_0000 + k), $urandom, '1, 8'(k), 32'(~k),
                                   2'(k)), $urandom);
    send_word(OP_ADD, rand_entry(), $urandom);
    send_word(OP_LOOKUP, rand_entry(), 32'(32'h0A00_0000 + ROUTE_DEPTH - 1));
    send_word(OP_LOOKUP, rand_entry(), 32'hC0A8_0000);
  endtask

  task automatic test_output_hold();
    int k;
    pace_gaps = 1'b0;
    burst_left = 0;
    hold_req = 1'b1;
    for (k = 0; k < 12; k++)
      send_word(($urandom_range(0, 1) == 0) ? OP_ADD : OP_LOOKUP, rand_entry(), pick_query());
    while (hold_req) @(negedge clk);
    pace_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int k;
    int n;
    while (words_sent < WORD_TARGET) begin
      pace_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        7, 8: begin
          n = $urandom_range(2, 16);
          for (k = 0; k < n; k++) send_word(OP_LOOKUP, rand_entry(), pick_query());
        end
        9: begin
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++) send_word(2'($urandom_range(0, 3)), rand_entry(), $urandom);
        end
        default: begin
          if ($urandom_range(0, 1) == 0) send_word(OP_CLEAR, rand_entry(), $urandom);
          n = $urandom_range(1, 18);
          for (k = 0; k < n; k++) send_word(OP_ADD, rand_entry(), $urandom);
          n = $urandom_range(2, 12);
          for (k = 0; k < n; k++) send_word(OP_LOOKUP, rand_entry(), pick_query());
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_ADD;
    route_dest = '0;
    route_gateway = '0;
    route_mask = '0;
    route_flags = '0;
    route_metric = '0;
    route_port = '0;
    query_addr = '0;
    route_cnt = 0;
    words_sent = 0;
    err_count = 0;
    cycle_count = 0;
    burst_left = 0;
    pace_gaps = 1'b1;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_first_match();
    test_default_route();
    test_table_full();
    test_output_hold();
    test_random_traffic();

    @(negedge clk);
    in_valid = 1'b0;
    while (due_answers.size() != 0) @(posedge clk);
    repeat (ROUTE_DEPTH + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("first_match_route_table regression: pass");
    end else begin
      $display("first_match_route_table regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/frt_pkg.sv
hw/rtl/frt_mem.sv
hw/rtl/frt_ctrl.sv
hw/rtl/first_match_route_table.sv
tb/sv/testbench.sv
